>>> sv/sacc_pkg.sv
// Shared types, constants and helpers for the set-associative cache tag controller.
// No dependencies; imported by the controller, the statistics bank and the checker.
package sacc_pkg;

  localparam int SET_COUNT_DEF = 1024;
  localparam int WAYS_DEF = 4;
  localparam int CNT_W_DEF = 48;

  localparam int ADDR_W = 32;
  localparam int RAW_SET_W = 15;
  localparam int OUT_CNT_W = 48;
  localparam int WB_OUT_W = 13;
  localparam int PADDR_W = 4;

  // Access codes
  localparam logic [1:0] FUNC_READ = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_WRITE_BACK = 2'd0;
  localparam logic [1:0] REG_RANDOM = 2'd1;
  localparam logic [1:0] REG_OFFSET = 2'd2;
  localparam logic [1:0] REG_INDEX = 2'd3;

  localparam logic [15:0] LFSR_SEED = 16'hACE1;
  localparam logic [15:0] LFSR_TAPS = 16'hB400;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic        line_fill;
    logic [12:0] writebacks;
    logic [1:0]  way_used;
    logic [47:0] read_total;
    logic [47:0] write_total;
    logic [47:0] read_hit_total;
    logic [47:0] write_hit_total;
    logic [47:0] mem_read_total;
    logic [47:0] mem_write_total;
  } rsp_t;

  // Events that advance the statistics counters
  typedef struct packed {
    logic rd;
    logic wr;
    logic rd_hit;
    logic wr_hit;
    logic mem_rd;
  } bump_t;

  function automatic logic [15:0] lfsr_step(input logic [15:0] x);
    logic [15:0] s;
    s = x >> 1;
    if (x[0]) s = s ^ LFSR_TAPS;
    return s;
  endfunction

  // Set bits before reduction to the set count
  function automatic logic [RAW_SET_W-1:0] raw_set(input logic [31:0] addr,
                                                   input logic [4:0] off,
                                                   input logic [3:0] idx);
    logic [31:0] s;
    logic [15:0] m;
    s = addr >> off;
    m = ~(16'hFFFF << idx);
    return RAW_SET_W'(s[15:0] & m);
  endfunction

  function automatic logic [31:0] tag_of(input logic [31:0] addr,
                                         input logic [4:0] off,
                                         input logic [3:0] idx);
    logic [5:0] sh;
    sh = 6'(off) + 6'(idx);
    return addr >> sh;
  endfunction

endpackage

>>> sv/sacc_stats.sv
// Bank of six saturating statistics counters for the cache tag controller.
// Depends on sacc_pkg for bump_t and the reported counter width.
module sacc_stats #(
  parameter int CNT_W = sacc_pkg::CNT_W_DEF,
  parameter int WB_W = 13
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  sacc_pkg::bump_t               bump,
  input  logic [WB_W-1:0]               wb_amount,
  output logic [sacc_pkg::OUT_CNT_W-1:0] totals [6]
);
  import sacc_pkg::*;

  localparam int SUM_W = ((CNT_W > WB_W) ? CNT_W : WB_W) + 1;
  localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

  logic [CNT_W-1:0] cnt [6];
  logic [WB_W-1:0]  amt [6];

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [WB_W-1:0] a);
    logic [SUM_W-1:0] s;
    s = SUM_W'(c) + SUM_W'(a);
    if (s > SUM_W'(CNT_MAX)) return CNT_MAX;
    return CNT_W'(s);
  endfunction

  // Map each event to its counter increment
  always_comb begin
    amt[0] = WB_W'(bump.rd);
    amt[1] = WB_W'(bump.wr);
    amt[2] = WB_W'(bump.rd_hit);
    amt[3] = WB_W'(bump.wr_hit);
    amt[4] = WB_W'(bump.mem_rd);
    amt[5] = wb_amount;
  end

  // Advance counters once per finished item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) cnt[i] <= '0;
    end else if (en) begin
      for (int i = 0; i < 6; i++) cnt[i] <= sat_add(cnt[i], amt[i]);
    end
  end

  // Report the low bits, zero-extended where the counters are narrower
  always_comb begin
    for (int i = 0; i < 6; i++) totals[i] = OUT_CNT_W'(64'(cnt[i]));
  end

endmodule

>>> sv/set_assoc_cache_tag_controller.sv
// Set-associative cache tag and state controller: tag/state memory, sequencer, config.
// Depends on sacc_pkg and sacc_stats.
//
// Each read or write reads its set row at the transfer when SET_COUNT is a power of
// two and compares and writes back the row in the next cycle; otherwise the states
// ST_DIV and ST_MOD first reduce the set index modulo SET_COUNT and read the row.
// A flush walks the whole tag memory one set per cycle. The set row memory holds
// one row per set with all ways and has one read and one write port. After reset
// the block clears every set of the memory and accepts no request meanwhile;
// register writes are taken anytime. Results show the statistics counters as
// they stand after the item.
module set_assoc_cache_tag_controller #(
  parameter int SET_COUNT = sacc_pkg::SET_COUNT_DEF,
  parameter int WAYS = sacc_pkg::WAYS_DEF,
  parameter int COUNTER_WIDTH = sacc_pkg::CNT_W_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        req_valid,
  output logic                        req_stall,
  input  sacc_pkg::req_t              req,
  output logic                        rsp_valid,
  input  logic                        rsp_stall,
  output sacc_pkg::rsp_t              rsp,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [sacc_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import sacc_pkg::*;

  localparam int WAYW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int SETW = (SET_COUNT > 1) ? $clog2(SET_COUNT) : 1;
  localparam int LINES = SET_COUNT * WAYS;
  localparam int WBW = $clog2(LINES + 1);
  localparam int POPW = $clog2(WAYS + 1);
  localparam bit SET_POW2 = ((SET_COUNT & (SET_COUNT - 1)) == 0);
  localparam bit WAYS_POW2 = ((WAYS & (WAYS - 1)) == 0);
  // Rounded-up reciprocals give the exact quotient for the operand ranges used
  localparam logic [31:0] SET_RECIP =
    32'(((64'(1) << 32) + 64'(SET_COUNT) - 64'(1)) / 64'(SET_COUNT));
  localparam logic [31:0] WAY_RECIP =
    32'(((64'(1) << 32) + 64'(WAYS) - 64'(1)) / 64'(WAYS));
  localparam logic [SETW-1:0] LAST_SET = SETW'(SET_COUNT - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_DIV = 3'd2;
  localparam logic [2:0] ST_MOD = 3'd3;
  localparam logic [2:0] ST_CMP = 3'd4;
  localparam logic [2:0] ST_FLUSH = 3'd5;
  localparam logic [2:0] ST_FEND = 3'd6;

  typedef struct packed {
    logic            valid;
    logic            dirty;
    logic [WAYW-1:0] age;
    logic [31:0]     tag;
  } line_t;
  typedef line_t [WAYS-1:0] row_t;

  // Configuration registers
  logic       write_back_mode;
  logic       random_replace;
  logic [4:0] offset_bits;
  logic [3:0] index_bits;

  logic [2:0]           state;
  logic [SETW-1:0]      clr_idx;
  logic [SETW-1:0]      set_q;
  logic [1:0]           cur_func;
  logic [31:0]          cur_tag;
  logic [RAW_SET_W-1:0] cur_raw;
  logic [47:0]          set_prod;
  logic [WBW-1:0]       wb_acc;
  logic [15:0]          lfsr;
  logic [WAYW-1:0]      pick;

  // Set row memory
  row_t            mem [SET_COUNT];
  row_t            rdata;
  logic            rd_en;
  logic [SETW-1:0] rd_addr;
  logic            wr_en;
  logic [SETW-1:0] wr_addr;
  row_t            wr_row;

  logic            accept;
  logic            fire;
  logic [SETW-1:0] in_set;
  logic [SETW-1:0] mod_set;
  logic [31:0]     mod_rem;
  row_t            reset_row;

  // Compare stage
  logic            is_acc;
  logic            is_wr;
  logic            hit_any;
  logic [WAYW-1:0] hit_way;
  logic            inv_any;
  logic [WAYW-1:0] inv_way;
  logic [WAYW-1:0] lru_way;
  logic [WAYW-1:0] vict;
  logic [WAYW-1:0] used;
  logic            do_touch;
  logic            fill;
  logic            acc_wb;
  logic            step_lfsr;
  row_t            cmp_row;
  logic [WAYW-1:0] old_age;

  // Flush stage
  row_t            flush_row;
  logic [POPW-1:0] pop;
  logic [WBW-1:0]  wb_total;

  logic            rsp_hit;
  logic            rsp_fill;
  logic [12:0]     rsp_wb;
  logic [1:0]      rsp_way;
  logic [31:0]     wb32;
  logic [31:0]     way32;
  logic [12:0]     wb_sat;

  bump_t           bump;
  logic [WBW-1:0]  bump_amt;
  logic [OUT_CNT_W-1:0] totals [6];

  logic [15:0] lfsr_nx;
  logic [47:0] way_prod;
  logic [31:0] way_rem;

  assign accept = req_valid && !req_stall;
  assign req_stall = (state != ST_IDLE);
  assign fire = !rsp_valid || !rsp_stall;
  assign pready = 1'b1;

  // Register port
  always_ff @(posedge clk) begin
    if (rst) begin
      write_back_mode <= 1'b0;
      random_replace <= 1'b0;
      offset_bits <= 5'd6;
      index_bits <= 4'd10;
    end else if (psel && penable && pwrite) begin
      case (paddr[3:2])
        REG_WRITE_BACK: write_back_mode <= pwdata[0];
        REG_RANDOM:     random_replace <= pwdata[0];
        REG_OFFSET:     offset_bits <= pwdata[4:0];
        REG_INDEX:      index_bits <= pwdata[3:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_WRITE_BACK: prdata = 32'(write_back_mode);
      REG_RANDOM:     prdata = 32'(random_replace);
      REG_OFFSET:     prdata = 32'(offset_bits);
      REG_INDEX:      prdata = 32'(index_bits);
      default:        prdata = '0;
    endcase
  end

  // Set index from the request; non-power-of-two counts use a reciprocal
  always_comb begin
    in_set = SETW'(32'(raw_set(req.address, offset_bits, index_bits)) &
                   32'(SET_COUNT - 1));
    mod_rem = 32'(cur_raw) - 32'(set_prod[47:32]) * 32'(SET_COUNT);
    mod_set = SETW'(mod_rem);
  end

  // Next LFSR value reduced to a way, registered ahead of use
  always_comb begin
    lfsr_nx = lfsr_step(lfsr);
    way_prod = 48'(lfsr_nx) * 48'(WAY_RECIP);
    if (WAYS_POW2) way_rem = 32'(lfsr_nx) & 32'(WAYS - 1);
    else way_rem = 32'(lfsr_nx) - 32'(way_prod[47:32]) * 32'(WAYS);
  end

  always_ff @(posedge clk) begin
    pick <= WAYW'(way_rem);
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      reset_row[w].valid = 1'b0;
      reset_row[w].dirty = 1'b0;
      reset_row[w].age = WAYW'(w);
      reset_row[w].tag = '0;
    end
  end

  // Tag compare, victim choice and row update
  always_comb begin
    is_acc = (cur_func == FUNC_READ) || (cur_func == FUNC_WRITE);
    is_wr = (cur_func == FUNC_WRITE);
    hit_any = 1'b0;
    hit_way = '0;
    inv_any = 1'b0;
    inv_way = '0;
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (rdata[w].valid && rdata[w].tag == cur_tag) begin
        hit_any = 1'b1;
        hit_way = WAYW'(w);
      end
      if (!rdata[w].valid) begin
        inv_any = 1'b1;
        inv_way = WAYW'(w);
      end
    end
    lru_way = '0;
    for (int w = 1; w < WAYS; w++) begin
      if (rdata[w].age > rdata[lru_way].age) lru_way = WAYW'(w);
    end
    if (inv_any) vict = inv_way;
    else if (random_replace) vict = pick;
    else vict = lru_way;

    cmp_row = rdata;
    used = '0;
    do_touch = 1'b0;
    fill = 1'b0;
    acc_wb = 1'b0;
    step_lfsr = 1'b0;
    if (is_acc) begin
      if (hit_any) begin
        used = hit_way;
        do_touch = 1'b1;
        if (is_wr) begin
          if (write_back_mode) cmp_row[hit_way].dirty = 1'b1;
          else acc_wb = 1'b1;
        end
      end else if (is_wr && !write_back_mode) begin
        acc_wb = 1'b1;
      end else begin
        used = vict;
        do_touch = 1'b1;
        fill = 1'b1;
        step_lfsr = !inv_any && random_replace;
        acc_wb = rdata[vict].valid && rdata[vict].dirty;
        cmp_row[vict].valid = 1'b1;
        cmp_row[vict].tag = cur_tag;
        cmp_row[vict].dirty = is_wr;
      end
    end
    // Outside random replacement, age the younger valid ways, make the used way youngest
    old_age = rdata[used].age;
    if (do_touch && !random_replace) begin
      for (int w = 0; w < WAYS; w++) begin
        if (cmp_row[w].valid && cmp_row[w].age < old_age) begin
          cmp_row[w].age = cmp_row[w].age + 1'b1;
        end
      end
      cmp_row[used].age = '0;
    end
  end

  // Count and clean dirty lines of the flushed row
  always_comb begin
    flush_row = rdata;
    pop = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (rdata[w].valid && rdata[w].dirty) begin
        pop = pop + 1'b1;
        flush_row[w].dirty = 1'b0;
      end
    end
    wb_total = wb_acc + WBW'(pop);
  end

  // Memory port control
  always_comb begin
    rd_en = 1'b0;
    rd_addr = '0;
    wr_en = 1'b0;
    wr_addr = set_q;
    wr_row = cmp_row;
    case (state)
      ST_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = clr_idx;
        wr_row = reset_row;
      end
      ST_IDLE: begin
        if (accept && req.func != FUNC_FLUSH && SET_POW2) begin
          rd_en = 1'b1;
          rd_addr = in_set;
        end else if (accept && req.func == FUNC_FLUSH) begin
          rd_en = 1'b1;
        end
      end
      ST_MOD: begin
        rd_en = 1'b1;
        rd_addr = mod_set;
      end
      ST_CMP: begin
        wr_en = is_acc;
      end
      ST_FLUSH: begin
        wr_en = 1'b1;
        wr_row = flush_row;
        rd_en = (set_q != LAST_SET);
        rd_addr = set_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_row;
    if (rd_en) rdata <= mem[rd_addr];
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      clr_idx <= '0;
      lfsr <= LFSR_SEED;
    end else begin
      case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
          if (clr_idx == LAST_SET) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (accept) begin
            if (req.func == FUNC_FLUSH) begin
              state <= ST_FLUSH;
              set_q <= '0;
              wb_acc <= '0;
            end else if (SET_POW2) begin
              state <= ST_CMP;
              set_q <= in_set;
            end else begin
              state <= ST_DIV;
            end
          end
        end
        ST_DIV: begin
          set_prod <= 48'(cur_raw) * 48'(SET_RECIP);
          state <= ST_MOD;
        end
        ST_MOD: begin
          set_q <= mod_set;
          state <= ST_CMP;
        end
        ST_CMP: begin
          if (fire) begin
            state <= ST_IDLE;
            if (step_lfsr) lfsr <= lfsr_nx;
          end
        end
        ST_FLUSH: begin
          wb_acc <= wb_total;
          set_q <= set_q + 1'b1;
          if (set_q == LAST_SET) state <= ST_FEND;
        end
        ST_FEND: begin
          if (fire) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // Latch the request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_func <= req.func;
      cur_tag <= tag_of(req.address, offset_bits, index_bits);
      cur_raw <= raw_set(req.address, offset_bits, index_bits);
    end
  end

  // Result fields for the finishing item
  always_comb begin
    bump = '0;
    if (state == ST_FEND) begin
      bump_amt = wb_acc;
      way32 = '0;
    end else begin
      bump.rd = is_acc && !is_wr;
      bump.wr = is_wr;
      bump.rd_hit = is_acc && !is_wr && hit_any;
      bump.wr_hit = is_wr && hit_any;
      bump.mem_rd = fill;
      bump_amt = WBW'(acc_wb);
      way32 = (is_acc && (hit_any || fill)) ? 32'(used) : '0;
    end
    wb32 = 32'(bump_amt);
    wb_sat = (wb32 > 32'd8191) ? 13'h1FFF : wb32[12:0];
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_CMP || state == ST_FEND) && fire) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_CMP || state == ST_FEND) && fire) begin
      rsp_hit <= (state == ST_CMP) && is_acc && hit_any;
      rsp_fill <= (state == ST_CMP) && fill;
      rsp_wb <= wb_sat;
      rsp_way <= way32[1:0];
    end
  end

  sacc_stats #(
    .CNT_W(COUNTER_WIDTH),
    .WB_W (WBW)
  ) u_stats (
    .clk      (clk),
    .rst      (rst),
    .en       ((state == ST_CMP || state == ST_FEND) && fire),
    .bump     (bump),
    .wb_amount(bump_amt),
    .totals   (totals)
  );

  always_comb begin
    rsp.hit = rsp_hit;
    rsp.line_fill = rsp_fill;
    rsp.writebacks = rsp_wb;
    rsp.way_used = rsp_way;
    rsp.read_total = totals[0];
    rsp.write_total = totals[1];
    rsp.read_hit_total = totals[2];
    rsp.write_hit_total = totals[3];
    rsp.mem_read_total = totals[4];
    rsp.mem_write_total = totals[5];
  end

endmodule

>>> sv/sacc_checker.sv
// Port-level checks for the cache tag controller, bound to the top level.
// Depends on sacc_pkg for the result type.
module sacc_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_stall,
  input logic           rsp_valid,
  input logic           rsp_stall,
  input sacc_pkg::rsp_t rsp
);
  import sacc_pkg::*;

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("result dropped while stalled");

  // One item at a time: a request transfer blocks the next cycle
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while busy");

  // A hit never fetches a block
  a_hit_no_fill: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> !rsp.line_fill)
    else $error("hit with line fill");

  // A hit causes at most one memory write
  a_hit_wb: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.hit |-> rsp.writebacks <= 13'd1)
    else $error("hit with several writebacks");

endmodule

bind set_assoc_cache_tag_controller sacc_checker u_sacc_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

>>> tb/set_assoc_cache_tag_controller_tb.sv
// Testbench for the set-associative cache tag controller: directed and random
// accesses checked against a built-in cache state predictor.
// Depends on sacc_pkg and the set_assoc_cache_tag_controller RTL.
module set_assoc_cache_tag_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sacc_pkg::*;

  localparam int NSETS = 1024;
  localparam int NWAYS = 4;
  localparam logic [47:0] CNT_SAT = 48'hFFFF_FFFF_FFFF;
  localparam int STALL_LIMIT = 40000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  set_assoc_cache_tag_controller i_dut (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Predicted cache state and settings
  logic        tag_valid [NSETS*NWAYS];
  logic [31:0] tag_store [NSETS*NWAYS];
  logic        tag_dirty [NSETS*NWAYS];
  logic [1:0]  tag_age   [NSETS*NWAYS];
  logic [15:0] victim_lfsr;
  logic [47:0] stat_cnt [6];
  logic        cfg_wb;
  logic        cfg_rand;
  logic [4:0]  cfg_off;
  logic [3:0]  cfg_idx;

  rsp_t expected_rsps[$];
  int   errors = 0;
  int   idle_cycles = 0;
  int   sent_count = 0;
  int   rsp_count = 0;
  int   hit_count = 0;
  int   wb_count = 0;
  bit   hold_off = 1'b0;
  bit   stall_en = 1'b0;

  function automatic logic [47:0] sat_add(logic [47:0] v, logic [47:0] amount);
    logic [48:0] s;
    s = {1'b0, v} + {1'b0, amount};
    return s[48] ? CNT_SAT : s[47:0];
  endfunction

  // Outside random replacement, age the younger valid ways and make the used way the newest
  function automatic void age_update(int base, int way);
    logic [1:0] old;
    old = tag_age[base+way];
    if (cfg_rand) return;
    for (int i = 0; i < NWAYS; i++)
      if (tag_valid[base+i] && tag_age[base+i] < old) tag_age[base+i]++;
    tag_age[base+way] = 2'd0;
  endfunction

  function automatic int choose_victim(int base);
    int v;
    for (int i = 0; i < NWAYS; i++)
      if (!tag_valid[base+i]) return i;
    if (!cfg_rand) begin
      v = 0;
      for (int i = 1; i < NWAYS; i++)
        if (tag_age[base+i] > tag_age[base+v]) v = i;
      return v;
    end
    victim_lfsr = victim_lfsr[0] ? ((victim_lfsr >> 1) ^ 16'hB400) : (victim_lfsr >> 1);
    return victim_lfsr % NWAYS;
  endfunction

  function automatic rsp_t predict_access(req_t r);
    rsp_t o;
    logic [63:0] setbits;
    logic [31:0] tagv;
    int base, found, v, wb;
    bit wr;
    o = '0;
    wb = 0;
    if (r.func == FUNC_READ || r.func == FUNC_WRITE) begin
      setbits = ({32'b0, r.address} >> cfg_off) & ((64'd1 << cfg_idx) - 1);
      tagv = r.address >> (int'(cfg_off) + int'(cfg_idx));
      base = int'(setbits % NSETS) * NWAYS;
      wr = (r.func == FUNC_WRITE);
      found = NWAYS;
      for (int w = 0; w < NWAYS; w++)
        if (found == NWAYS && tag_valid[base+w] && tag_store[base+w] == tagv) found = w;
      stat_cnt[wr ? 1 : 0] = sat_add(stat_cnt[wr ? 1 : 0], 1);
      if (found < NWAYS) begin
        o.hit = 1'b1;
        o.way_used = found[1:0];
        stat_cnt[wr ? 3 : 2] = sat_add(stat_cnt[wr ? 3 : 2], 1);
        if (wr) begin
          if (cfg_wb) tag_dirty[base+found] = 1'b1;
          else wb = 1;
        end
        age_update(base, found);
      end else if (wr && !cfg_wb) begin
        wb = 1;
      end else begin
        v = choose_victim(base);
        o.line_fill = 1'b1;
        o.way_used = v[1:0];
        stat_cnt[4] = sat_add(stat_cnt[4], 1);
        if (tag_valid[base+v] && tag_dirty[base+v]) wb = 1;
        tag_valid[base+v] = 1'b1;
        tag_store[base+v] = tagv;
        tag_dirty[base+v] = wr;
        age_update(base, v);
      end
    end else if (r.func == FUNC_FLUSH) begin
      for (int i = 0; i < NSETS*NWAYS; i++)
        if (tag_valid[i] && tag_dirty[i]) begin
          wb++;
          tag_dirty[i] = 1'b0;
        end
    end
    stat_cnt[5] = sat_add(stat_cnt[5], 48'(wb));
    o.writebacks = (wb > 8191) ? 13'd8191 : 13'(wb);
    o.read_total = stat_cnt[0];
    o.write_total = stat_cnt[1];
    o.read_hit_total = stat_cnt[2];
    o.write_hit_total = stat_cnt[3];
    o.mem_read_total = stat_cnt[4];
    o.mem_write_total = stat_cnt[5];
    return o;
  endfunction

  // Offer one request, predict it at its transfer
  task automatic send_access(logic [1:0] f, logic [31:0] a);
    req_valid <= 1'b1;
    req.func <= f;
    req.address <= a;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    expected_rsps.push_back(predict_access('{func: f, address: a}));
    sent_count++;
    @(negedge clk);
    if ($urandom_range(0, 3) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
  endtask

  task automatic drain_pipe();
    req_valid <= 1'b0;
    while (expected_rsps.size() != 0) @(negedge clk);
    repeat (NSETS + 20) @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= PADDR_W'({idx, 2'b00}); pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_WRITE_BACK: cfg_wb = val[0];
      REG_RANDOM:     cfg_rand = val[0];
      REG_OFFSET:     cfg_off = val[4:0];
      default:        cfg_idx = val[3:0];
    endcase
    // Leave the bus idle before the next transfer
    @(negedge clk);
  endtask

  task automatic set_mode(bit wbm, bit rnd, logic [4:0] off, logic [3:0] idx);
    drain_pipe();
    write_reg(REG_WRITE_BACK, 32'(wbm));
    write_reg(REG_RANDOM, 32'(rnd));
    write_reg(REG_OFFSET, 32'(off));
    write_reg(REG_INDEX, 32'(idx));
  endtask

  // Address mostly within a small tag pool so that hits, conflicts and evictions occur
  function automatic logic [31:0] pool_addr();
    logic [31:0] a;
    a = $urandom();
    if ($urandom_range(0, 9) != 0) begin
      a = a & ((32'd1 << (int'(cfg_off) + int'(cfg_idx) > 31 ? 31 :
                           int'(cfg_off) + int'(cfg_idx))) - 1);
      a = a & ~(32'hF << cfg_off) | (32'($urandom_range(0, 3)) << cfg_off);
      a = a | (32'($urandom_range(0, 6)) << (int'(cfg_off) + int'(cfg_idx) > 31 ? 31 :
                                             int'(cfg_off) + int'(cfg_idx)));
    end
    return a;
  endfunction

  task automatic test_directed();
    send_access(FUNC_READ, 32'h0000_0000);
    send_access(FUNC_READ, 32'h0000_0000);
    send_access(FUNC_WRITE, 32'hFFFF_FFFF);
    send_access(FUNC_WRITE, 32'h0000_0000);
    send_access(FUNC_FLUSH, 32'hFFFF_FFFF);
    send_access(2'd3, 32'h1234_5678);
    set_mode(1'b1, 1'b0, 5'd6, 4'd10);
    for (int i = 0; i < 6; i++) send_access(FUNC_WRITE, 32'(i) << 16);
    send_access(FUNC_READ, 32'hFFFF_FFFF);
    send_access(FUNC_FLUSH, 32'h0);
    send_access(FUNC_FLUSH, 32'h0);
    set_mode(1'b1, 1'b1, 5'd31, 4'd0);
    for (int i = 0; i < 6; i++) send_access(FUNC_WRITE, {i[0], 31'h0});
    send_access(FUNC_FLUSH, 32'h0);
  endtask

  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) send_access(FUNC_READ, pool_addr());
      else if (r < 92) send_access(FUNC_WRITE, pool_addr());
      else if (r < 96) send_access(FUNC_FLUSH, $urandom());
      else send_access(2'd3, $urandom());
    end
  endtask

  // Hold the response side off while requests keep arriving
  task automatic test_backpressure();
    hold_off = 1'b1;
    fork
      begin
        repeat (200) @(negedge clk);
        hold_off = 1'b0;
      end
      test_random(20);
    join
  endtask

  // Response stall pattern
  always @(negedge clk) begin
    if (hold_off) rsp_stall <= 1'b1;
    else if (stall_en) rsp_stall <= ($urandom_range(0, 4) == 0);
    else rsp_stall <= 1'b0;
  end

  // Compare each response with the oldest prediction
  always @(posedge clk) begin
    rsp_t e;
    if (!rst && rsp_valid && !rsp_stall) begin
      rsp_count++;
      if (expected_rsps.size() == 0) begin
        $error("unexpected response %p", rsp);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (rsp.hit) hit_count++;
        if (rsp.writebacks != 0) wb_count++;
        if (rsp.hit !== e.hit) begin
          $error("hit exp %0h got %0h", e.hit, rsp.hit); errors++;
        end
        if (rsp.line_fill !== e.line_fill) begin
          $error("line_fill exp %0h got %0h", e.line_fill, rsp.line_fill); errors++;
        end
        if (rsp.writebacks !== e.writebacks) begin
          $error("writebacks exp %0d got %0d", e.writebacks, rsp.writebacks); errors++;
        end
        if (rsp.way_used !== e.way_used) begin
          $error("way_used exp %0d got %0d", e.way_used, rsp.way_used); errors++;
        end
        if (rsp.read_total !== e.read_total) begin
          $error("read_total exp %0d got %0d", e.read_total, rsp.read_total); errors++;
        end
        if (rsp.write_total !== e.write_total) begin
          $error("write_total exp %0d got %0d", e.write_total, rsp.write_total); errors++;
        end
        if (rsp.read_hit_total !== e.read_hit_total) begin
          $error("read_hit_total exp %0d got %0d", e.read_hit_total, rsp.read_hit_total);
          errors++;
        end
        if (rsp.write_hit_total !== e.write_hit_total) begin
          $error("write_hit_total exp %0d got %0d", e.write_hit_total, rsp.write_hit_total);
          errors++;
        end
        if (rsp.mem_read_total !== e.mem_read_total) begin
          $error("mem_read_total exp %0d got %0d", e.mem_read_total, rsp.mem_read_total);
          errors++;
        end
        if (rsp.mem_write_total !== e.mem_write_total) begin
          $error("mem_write_total exp %0d got %0d", e.mem_write_total, rsp.mem_write_total);
          errors++;
        end
      end
    end
  end

  // Watchdog on cycles with no transfer
  always @(posedge clk) begin
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || rst || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NSETS*NWAYS; i++) begin
      tag_valid[i] = 1'b0;
      tag_store[i] = '0;
      tag_dirty[i] = 1'b0;
      tag_age[i] = 2'(i % NWAYS);
    end
    victim_lfsr = 16'hACE1;
    for (int k = 0; k < 6; k++) stat_cnt[k] = '0;
    cfg_wb = 1'b0; cfg_rand = 1'b0; cfg_off = 5'd6; cfg_idx = 4'd10;
    repeat (3) @(negedge clk);
    rst <= 1'b0;
    test_directed();
    set_mode(1'b0, 1'b0, 5'd4, 4'd3);
    stall_en = 1'b1;
    test_random(300);
    set_mode(1'b1, 1'b0, 5'd0, 4'd2);
    test_random(400);
    test_backpressure();
    set_mode(1'b1, 1'b1, 5'd20, 4'd4);
    test_random(400);
    set_mode(1'b0, 1'b1, 5'd7, 4'd10);
    test_random(300);
    set_mode(1'b1, 1'b0, 5'd12, 4'd1);
    test_random(400);
    drain_pipe();
    $display("Covered %0d requests and %0d responses over eight register settings;",
             sent_count, rsp_count);
    $display("%0d hits and %0d responses with write-backs.", hit_count, wb_count);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

>>> filelist.f
sv/sacc_pkg.sv
sv/sacc_stats.sv
sv/set_assoc_cache_tag_controller.sv
sv/sacc_checker.sv
tb/set_assoc_cache_tag_controller_tb.sv
